@@ sv/hfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg: shared constants, types and tables of the hilbert frequency shifter
// Sizes, control struct, state encoding, and the sine and coefficient tables
// built in fixed point at elaboration.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int TAPS            = 63;
  localparam int RING_DEPTH      = 64;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int MID       = (TAPS - 1) / 2;
  localparam int CNT_W     = $clog2(RING_DEPTH);
  localparam int SAMPLE_W  = 16;
  localparam int PHASE_W   = 24;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 40;
  localparam int HIL_W     = ACC_W - 16;
  localparam int MIX_W     = HIL_W + SAMPLE_W + 1;
  localparam int COS_DEN   = 4 * (TAPS - 1);

  localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;
  localparam longint      TWO_OVER_PI_Q30 = 64'sd683565276;
  localparam longint      ONE_Q30         = 64'sd1073741824;
  localparam logic [63:0] TAYLOR_DIV [6]  = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_SIZE];
  typedef logic signed [COEF_W-1:0]   coef_rom_t [RING_DEPTH];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_TRIG,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic shift_in;
    logic rotate;
    logic mac_clear;
    logic mac_step;
    logic mac_drain;
    logic phase_step;
    logic trig;
    logic mul;
  } ctrl_t;

  // q30 sine on the first quadrant by taylor series, sign from the quadrant
  function automatic logic signed [31:0] quarter_sin_q30(input logic [63:0] x,
                                                         input logic [1:0]  quad);
    logic [63:0] term;
    longint      sum;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = ((term * x) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum > ONE_Q30) sum = ONE_Q30;
    if (sum < 0)       sum = 0;
    if (quad[1]) sum = -sum;
    return 32'(sum);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(input logic signed [31:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
    r   = (mag * 64'd32767 + 64'd536870912) >> 30;
    return (v < 0) ? -SAMPLE_W'(r) : SAMPLE_W'(r);
  endfunction

  // restoring long division, used for table building only
  function automatic logic [63:0] ratio64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    for (int i = 0; i < SINE_SIZE; i++) begin
      p = 64'(i) * 64'd4;
      q = p / SINE_SIZE;
      r = p % SINE_SIZE;
      if (q[0]) r = 64'(SINE_SIZE) - r;
      x = (PI_HALF_Q30 * r) / SINE_SIZE;
      rom[i] = q30_to_q15(quarter_sin_q30(x, q[1:0]));
    end
    return rom;
  endfunction

  // hamming windowed hilbert taps in q16, zero past the last tap
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t   rom;
    int          m;
    int          am;
    logic [63:0] num;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] hu;
    longint      c;
    longint      w;
    for (int k = 0; k < RING_DEPTH; k++) begin
      rom[k] = '0;
      m      = k - MID;
      if (k < TAPS && (m & 1) != 0) begin
        num = 64'(4 * k + TAPS - 1) % COS_DEN;
        p   = num * 64'd4;
        q   = p / COS_DEN;
        r   = p % COS_DEN;
        if (q[0]) r = 64'(COS_DEN) - r;
        x   = (PI_HALF_Q30 * r) / COS_DEN;
        c   = longint'(quarter_sin_q30(x, q[1:0]));
        w   = (54 * ONE_Q30 - 46 * c) / 100;
        am  = (m < 0) ? -m : m;
        hu  = 64'(w * TWO_OVER_PI_Q30) >> 30;
        hu  = ratio64(hu, 64'(am));
        hu  = (hu + 64'd8192) >> 14;
        rom[k] = (m < 0) ? -COEF_W'(hu) : COEF_W'(hu);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

@@ sv/hfs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_cell: one sample cell of the delay ring
// Holds one sample and takes its neighbour's value when enabled.
// ----------------------------------------------------------------------------
module hfs_cell
  import hfs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic signed [SAMPLE_W-1:0] d_i,
  output logic signed [SAMPLE_W-1:0] q_o
);

  logic signed [SAMPLE_W-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

@@ sv/hfs_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_chain: delay ring built as a circular chain of sample cells
// A new sample shifts in at the head; during filtering the chain rotates once
// round so every delay passes the tap at the tail.
// ----------------------------------------------------------------------------
module hfs_chain
  import hfs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0] tap_o
);

  logic signed [SAMPLE_W-1:0] cell_d [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] cell_q [RING_DEPTH];
  logic                       cell_en;

  assign cell_en = ctrl_i.shift_in | ctrl_i.rotate;

  for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      // head takes the new sample, or the tail when rotating
      assign cell_d[g] = ctrl_i.shift_in ? sample_i : cell_q[RING_DEPTH-1];
    end else begin : g_body
      assign cell_d[g] = cell_q[g-1];
    end

    hfs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (cell_en),
      .d_i    (cell_d[g]),
      .q_o    (cell_q[g])
    );
  end

  assign tap_o = cell_q[RING_DEPTH-1];

endmodule

@@ sv/hfs_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_mac: hilbert fir multiply-accumulate
// One tap per cycle from the chain tail, registered product, then accumulate.
// Also catches the centre-delayed sample as it passes.
// ----------------------------------------------------------------------------
module hfs_mac
  import hfs_pkg::*;
(
  input  logic                       clk_i,
  input  ctrl_t                      ctrl_i,
  input  logic [CNT_W-1:0]           cnt_i,
  input  logic signed [SAMPLE_W-1:0] tap_i,
  output logic signed [ACC_W-1:0]    acc_o,
  output logic signed [SAMPLE_W-1:0] centre_o
);

  logic [CNT_W-1:0]           k;
  logic signed [COEF_W-1:0]   coef;
  logic signed [PROD_W-1:0]   p_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] centre_q;

  // after t rotations the tail holds the sample delayed by depth-1-t
  assign k    = CNT_W'(RING_DEPTH - 1) - cnt_i;
  assign coef = COEF_ROM[k];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac_clear) begin
      p_q   <= '0;
      acc_q <= '0;
    end else if (ctrl_i.mac_step) begin
      p_q   <= tap_i * coef;
      acc_q <= acc_q + ACC_W'(p_q);
    end else if (ctrl_i.mac_drain) begin
      acc_q <= acc_q + ACC_W'(p_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac_step && k == CNT_W'(MID)) begin
      centre_q <= tap_i;
    end
  end

  assign acc_o    = acc_q;
  assign centre_o = centre_q;

endmodule

@@ sv/hfs_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_mixer: phase accumulator and quadrature mixer
// Rounds the fir sum, looks up sin and cos, forms d*cos - hil*sin and
// rounds and saturates it to q1.15.
// ----------------------------------------------------------------------------
module hfs_mixer
  import hfs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic signed [PHASE_W-1:0]  incr_i,
  input  logic signed [ACC_W-1:0]    acc_i,
  input  logic signed [SAMPLE_W-1:0] centre_i,
  output logic signed [SAMPLE_W-1:0] y_o
);

  logic [PHASE_W-1:0]                 phase_q;
  logic [SINE_TABLE_BITS-1:0]         sin_idx;
  logic [SINE_TABLE_BITS-1:0]         cos_idx;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [HIL_W-1:0]            hil_q;
  logic signed [SAMPLE_W-1:0]         sin_q;
  logic signed [SAMPLE_W-1:0]         cos_q;
  logic signed [2*SAMPLE_W-1:0]       pd_q;
  logic signed [HIL_W+SAMPLE_W-1:0]   ph_q;
  logic signed [MIX_W-1:0]            mix;
  logic signed [MIX_W-16:0]           mix_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctrl_i.phase_step) begin
      phase_q <= phase_q + incr_i;
    end
  end

  assign sin_idx = phase_q[PHASE_W-1 -: SINE_TABLE_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(SINE_SIZE / 4);
  assign acc_r   = acc_i + ACC_W'(32'sd32768);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.trig) begin
      hil_q <= acc_r[ACC_W-1:16];
      sin_q <= SINE_ROM[sin_idx];
      cos_q <= SINE_ROM[cos_idx];
    end
    if (ctrl_i.mul) begin
      pd_q <= centre_i * cos_q;
      ph_q <= hil_q * sin_q;
    end
  end

  assign mix    = MIX_W'(pd_q) - MIX_W'(ph_q) + MIX_W'(32'sd16384);
  assign mix_sh = mix[MIX_W-1:15];

  always_comb begin
    if (mix_sh > (MIX_W-15)'(32'sd32767)) begin
      y_o = 16'sh7fff;
    end else if (mix_sh < (MIX_W-15)'(-32'sd32768)) begin
      y_o = -16'sh8000;
    end else begin
      y_o = mix_sh[SAMPLE_W-1:0];
    end
  end

endmodule

@@ sv/hilbert_frequency_shifter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_frequency_shifter: single-sideband frequency shifter
// Hilbert fir over a 64-cell delay ring, phase accumulator and sin/cos mixer.
// ----------------------------------------------------------------------------
// With a non-zero phase increment no new sample is taken until the last one
// has passed through the whole sequence: the fir multiplier walks the 64
// cells of the rotating delay ring one tap per cycle, followed by a drain,
// a table read, a product and an output step. The result is held in an
// output register; a finished result waits in the output state until that
// register is free, and no new sample is taken while a result sits there
// stalled, so output stall delays the next acceptance. A zero increment
// bypasses the shifter: the sample goes straight to the output register,
// one per cycle while the output is not stalled, and no state changes.
// Write the phase increment only while idle.
module hilbert_frequency_shifter
  import hfs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] shifted_sample_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic signed [PHASE_W-1:0]  cfg_data_i
);

  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic signed [PHASE_W-1:0]  incr_q;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_data_q;
  logic                       in_fire;
  logic                       out_free;
  logic                       bypass;
  logic                       out_load;
  ctrl_t                      ctrl;
  logic signed [SAMPLE_W-1:0] tap;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [SAMPLE_W-1:0] mix_y;

  assign cfg_ready_o = 1'b1;
  assign bypass      = (incr_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      incr_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !bypass) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RING_DEPTH - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_TRIG;
      ST_TRIG:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl     = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (bypass) begin
            out_load = 1'b1;
          end else begin
            ctrl.shift_in   = 1'b1;
            ctrl.mac_clear  = 1'b1;
            ctrl.phase_step = 1'b1;
          end
        end
      end
      ST_MAC: begin
        ctrl.rotate   = 1'b1;
        ctrl.mac_step = 1'b1;
      end
      ST_DRAIN: ctrl.mac_drain = 1'b1;
      ST_TRIG:  ctrl.trig      = 1'b1;
      ST_MUL:   ctrl.mul       = 1'b1;
      ST_OUT:   out_load       = out_free;
      default: begin
        ctrl     = '0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= (state_q == ST_IDLE) ? sample_in_i : mix_y;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shifted_sample_o = out_data_q;

  hfs_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (sample_in_i),
    .tap_o    (tap)
  );

  hfs_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .cnt_i    (cnt_q),
    .tap_i    (tap),
    .acc_o    (acc),
    .centre_o (centre)
  );

  hfs_mixer u_mixer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .incr_i   (incr_q),
    .acc_i    (acc),
    .centre_i (centre),
    .y_o      (mix_y)
  );

endmodule

@@ sv/hfs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_checker: port-level checks of the frequency shifter
// Tracks the phase increment and the number of requests in flight.
// ----------------------------------------------------------------------------
module hfs_checker
  import hfs_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic signed [SAMPLE_W-1:0] sample_in_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [SAMPLE_W-1:0] shifted_sample_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic signed [PHASE_W-1:0]  cfg_data_i
);

  logic                      in_acc;
  logic                      out_acc;
  logic signed [PHASE_W-1:0] incr_q;
  logic [2:0]                pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incr_q <= '0;
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        incr_q <= cfg_data_i;
      end
    end
  end

  // bypass hands the sample over unchanged on the next cycle
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && incr_q == '0 |=> out_valid_o && shifted_sample_o == $past(sample_in_i))
    else $error("bypass result wrong or late");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && incr_q != '0 |=> in_stall_o)
    else $error("request taken while filtering");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("result without a request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd2)
    else $error("too many requests in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shifted_sample_o))
    else $error("stalled result changed");

endmodule

bind hilbert_frequency_shifter hfs_checker u_checker (.*);
